[rtl/lef_pkg.sv]
// Shared constants, result codes and character classes for the line tokenizer.
// Used by lef_mac10, lef_scan and line_edit_field_tokenizer_unit; no dependencies.
package lef_pkg;

  // Character codes the line editor and the scanner react to.
  localparam logic [7:0] ASCII_BS    = 8'd8;
  localparam logic [7:0] ASCII_LF    = 8'd10;
  localparam logic [7:0] ASCII_CR    = 8'd13;
  localparam logic [7:0] ASCII_SPACE = 8'd32;
  localparam logic [7:0] ASCII_TILDE = 8'd126;
  localparam logic [7:0] ASCII_DEL   = 8'd127;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_UP_A  = 8'd65;
  localparam logic [7:0] ASCII_UP_Z  = 8'd90;
  localparam logic [7:0] ASCII_LO_A  = 8'd97;
  localparam logic [7:0] ASCII_LO_Z  = 8'd122;

  // Field kind codes carried on the result tuser.
  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // Result field widths and their place in the result tdata.
  localparam int unsigned FIDX_OUT_W  = 3;
  localparam int unsigned START_OUT_W = 6;
  localparam int unsigned LEN_OUT_W   = 7;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned TOTAL_OUT_W = 4;
  localparam int unsigned DATA_BITS   = FIDX_OUT_W + START_OUT_W + LEN_OUT_W + VAL_W
                                        + TOTAL_OUT_W;
  localparam int unsigned TDATA_W     = ((DATA_BITS + 7) / 8) * 8;
  localparam int unsigned TPAD_W      = TDATA_W - DATA_BITS;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= ASCII_UP_A) && (c <= ASCII_UP_Z)) ||
           ((c >= ASCII_LO_A) && (c <= ASCII_LO_Z));
  endfunction

endpackage

[rtl/lef_mac10.sv]
// Decimal accumulate unit: acc * 10 + (char - '0'), modulo 2^32.
// Depends on lef_pkg for the value width and the digit base code.
module lef_mac10 import lef_pkg::*; (
  input  logic [VAL_W-1:0] acc_i,
  input  logic [7:0]       char_i,
  output logic [VAL_W-1:0] acc_o
);

  // Times ten as two shifted copies, then the digit offset.
  assign acc_o = (acc_i << 3) + (acc_i << 1) + VAL_W'(char_i) - VAL_W'(ASCII_ZERO);

endmodule

[rtl/lef_scan.sv]
// Line scan sequencer: walks the stored line once, builds field records, then sends
// one result item per recorded field (one empty item if none). Depends on lef_pkg and lef_mac10.
module lef_scan import lef_pkg::*; #(
  parameter int unsigned LINE_CHARS  = 64,
  parameter int unsigned FIELD_LIMIT = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [$clog2(LINE_CHARS+1)-1:0]      line_len_i,
  output logic                                 idle_o,
  output logic                                 rd_en_o,
  output logic [$clog2(LINE_CHARS)-1:0]        rd_addr_o,
  input  logic [7:0]                           rd_data_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [TDATA_W-1:0]                   m_axis_tdata_o,
  output logic [KIND_W-1:0]                    m_axis_tuser_o,
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned CNT_W  = $clog2(LINE_CHARS + 1);
  localparam int unsigned POS_W  = $clog2(LINE_CHARS);
  localparam int unsigned FCNT_W = $clog2(FIELD_LIMIT + 1);
  localparam int unsigned FIDX_W = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    len_q;
  logic [CNT_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic [POS_W-1:0]    rd_pos_q;
  logic                prev_delim_q;
  logic [FCNT_W-1:0]   n_q;
  logic [FIDX_W-1:0]   cur_q;
  logic [VAL_W-1:0]    acc_q;
  logic [CNT_W-1:0]    run_len_q;
  logic [FIDX_W-1:0]   e_idx_q;

  // Output register.
  logic                      out_vld_q;
  logic [FIDX_OUT_W-1:0]     out_idx_q;
  logic [KIND_W-1:0]         out_kind_q;
  logic [START_OUT_W-1:0]    out_start_q;
  logic [LEN_OUT_W-1:0]      out_len_q;
  logic [VAL_W-1:0]          out_val_q;
  logic [TOTAL_OUT_W-1:0]    out_total_q;
  logic                      out_last_q;

  // Field records, one per reported field.
  logic [POS_W-1:0]    rec_st  [FIELD_LIMIT];
  logic [CNT_W-1:0]    rec_len [FIELD_LIMIT];
  logic [VAL_W-1:0]    rec_val [FIELD_LIMIT];
  logic                rec_num [FIELD_LIMIT];

  logic                c_digit;
  logic                c_alnum;
  logic                new_fld;
  logic                fields_full;
  logic                brk;
  logic                step;
  logic                more;
  logic                issue;
  logic                scan_done;
  logic [FIDX_W-1:0]   wi;
  logic [VAL_W-1:0]    mac_acc;
  logic [VAL_W-1:0]    mac_out;
  logic [CNT_W-1:0]    run_len_d;
  logic [FIDX_W-1:0]   ld_k;
  logic                ld_empty;
  logic                ld_last;

  // Classify the character that came back from the line store.
  always_comb begin
    c_digit     = is_digit(rd_data_i);
    c_alnum     = c_digit || is_letter(rd_data_i);
    new_fld     = (state_q == S_SCAN) && rd_vld_q && c_alnum && prev_delim_q;
    fields_full = (n_q == FCNT_W'(FIELD_LIMIT));
    brk         = new_fld && fields_full;
    step        = (state_q == S_SCAN) && rd_vld_q && c_alnum && !brk;
    wi          = new_fld ? FIDX_W'(n_q) : cur_q;
    mac_acc     = new_fld ? '0 : acc_q;
    run_len_d   = new_fld ? CNT_W'(1) : run_len_q + CNT_W'(1);
    more        = (idx_q < len_q);
    issue       = (state_q == S_SCAN) && more && !brk;
    scan_done   = (state_q == S_SCAN) && (brk || (!more && !rd_vld_q));
  end

  lef_mac10 u_mac10 (
    .acc_i  (mac_acc),
    .char_i (rd_data_i),
    .acc_o  (mac_out)
  );

  assign rd_en_o   = issue;
  assign rd_addr_o = idx_q[POS_W-1:0];
  assign idle_o    = (state_q == S_IDLE);

  // Record to load into the output register next.
  always_comb begin
    ld_k     = (state_q == S_SCAN) ? '0 : e_idx_q + FIDX_W'(1);
    ld_empty = (n_q == '0);
    ld_last  = ld_empty || ((FCNT_W'(ld_k) + FCNT_W'(1)) == n_q);
  end

  // Field record writes during the scan.
  always_ff @(posedge clk_i) begin
    if (step) begin
      rec_len[wi] <= run_len_d;
      rec_val[wi] <= mac_out;
      if (new_fld) begin
        rec_st[wi]  <= rd_pos_q;
        rec_num[wi] <= c_digit;
      end
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      len_q        <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_pos_q     <= '0;
      prev_delim_q <= 1'b1;
      n_q          <= '0;
      cur_q        <= '0;
      acc_q        <= '0;
      run_len_q    <= '0;
      e_idx_q      <= '0;
      out_vld_q    <= 1'b0;
      out_idx_q    <= '0;
      out_kind_q   <= KIND_EMPTY;
      out_start_q  <= '0;
      out_len_q    <= '0;
      out_val_q    <= '0;
      out_total_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            len_q        <= line_len_i;
            idx_q        <= '0;
            rd_vld_q     <= 1'b0;
            prev_delim_q <= 1'b1;
            n_q          <= '0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld_q <= issue;
          rd_pos_q <= idx_q[POS_W-1:0];
          if (issue) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          if (rd_vld_q) begin
            prev_delim_q <= !c_alnum;
          end
          if (step) begin
            acc_q     <= mac_out;
            run_len_q <= run_len_d;
            cur_q     <= wi;
            if (new_fld) begin
              n_q <= n_q + FCNT_W'(1);
            end
          end
          if (scan_done) begin
            state_q <= S_EMIT;
            e_idx_q <= '0;
          end
        end
        S_EMIT: begin
          if (out_vld_q && m_axis_tready_i) begin
            if (out_last_q) begin
              state_q <= S_IDLE;
            end else begin
              e_idx_q <= ld_k;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Load a result when the scan ends or the previous result is taken.
      if (scan_done || (state_q == S_EMIT && out_vld_q && m_axis_tready_i && !out_last_q))
      begin
        out_vld_q   <= 1'b1;
        out_total_q <= TOTAL_OUT_W'(n_q);
        out_last_q  <= ld_last;
        if (ld_empty) begin
          out_idx_q   <= '0;
          out_kind_q  <= KIND_EMPTY;
          out_start_q <= '0;
          out_len_q   <= '0;
          out_val_q   <= '0;
        end else begin
          out_idx_q   <= FIDX_OUT_W'(ld_k);
          out_kind_q  <= rec_num[ld_k] ? KIND_NUM : KIND_ALPHA;
          out_start_q <= START_OUT_W'(rec_st[ld_k]);
          out_len_q   <= LEN_OUT_W'(rec_len[ld_k]);
          out_val_q   <= rec_num[ld_k] ? rec_val[ld_k] : '0;
        end
      end else if (state_q == S_EMIT && out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{TPAD_W{1'b0}}, out_total_q, out_val_q, out_len_q,
                            out_start_q, out_idx_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/line_edit_field_tokenizer_unit.sv]
// Top level of the line tokenizer: line editing, the line store and the scan.
// Depends on lef_pkg and lef_scan (which uses lef_mac10).
//
//  Channel   Dir  Signals                  Content
//  s_axis    in   tvalid/tready/tdata[7:0] rx_byte
//  m_axis    out  tvalid/tready/tdata/     one field record per item,
//                 tuser/tlast              tlast on the final field of a line
//
// A byte that edits the line is taken while no scan runs. A byte that ends the
// line starts a scan of the line store, one character per cycle through its single
// read port; the result items follow, and the result side may stall them. No input
// item is accepted from the end of a line until its last result item is taken.
// Reset clears the character count; the line store holds no reset value and only
// written positions are scanned.
module line_edit_field_tokenizer_unit import lef_pkg::*; #(
  parameter int unsigned LINE_CHARS  = 64,
  parameter int unsigned FIELD_LIMIT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [2:0] field_index, [8:3] field_start, [15:9] field_length,
  // [47:16] field_value, [51:48] field_total, [55:52] zero
  output logic [TDATA_W-1:0]  m_axis_tdata_o,
  output logic [KIND_W-1:0]   m_axis_tuser_o,  // [1:0] field_kind
  output logic                m_axis_tlast_o   // last_field
);

  localparam int unsigned CNT_W = $clog2(LINE_CHARS + 1);
  localparam int unsigned POS_W = $clog2(LINE_CHARS);

  logic [7:0]        line_mem [LINE_CHARS];
  logic [7:0]        rd_data_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              scan_idle;
  logic              rd_en;
  logic [POS_W-1:0]  rd_addr;
  logic              accept;
  logic              is_erase;
  logic              is_eol;
  logic              is_print;
  logic              line_full;
  logic              start;
  logic              store;

  // Decode the received byte.
  always_comb begin
    accept    = s_axis_tvalid_i && scan_idle;
    is_erase  = (s_axis_tdata_i == ASCII_BS) || (s_axis_tdata_i == ASCII_DEL);
    is_eol    = (s_axis_tdata_i == ASCII_LF) || (s_axis_tdata_i == ASCII_CR);
    is_print  = (s_axis_tdata_i >= ASCII_SPACE) && (s_axis_tdata_i <= ASCII_TILDE);
    line_full = (cnt_q == CNT_W'(LINE_CHARS));
    start     = accept && !is_erase && (is_eol || line_full);
    store     = accept && !is_erase && !is_eol && !line_full && is_print;
  end

  assign s_axis_tready_o = scan_idle;

  // Character count: erase, append, or clear at the end of a line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      if (is_erase) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end else if (start) begin
        cnt_q <= '0;
      end else if (store) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Line store: one write port for editing, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (store) begin
      line_mem[cnt_q[POS_W-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  lef_scan #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .line_len_i      (cnt_q),
    .idle_o          (scan_idle),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
